// ===== sv/bfkn_pkg.sv =====
// Package: shared constants, types and state codes for the k-nearest search block.
package bfkn_pkg;

	localparam int MAX_POINTS_DEF    = 1024;
	localparam int DIMS_DEF          = 4;
	localparam int MAX_NEIGHBORS_DEF = 16;
	localparam int COORD_BITS_DEF    = 16;

	localparam int IDX_W   = 10;
	localparam int RANK_W  = 4;
	localparam int DIST_W  = 34;
	localparam int NCNT_W  = 5;
	localparam int PCNT_W  = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT    = 1'd1;

	localparam logic MODE_STORE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Control from the sequencer to the candidate list.
	typedef struct packed {
		logic clear;
		logic offer;
	} list_ctrl_t;

endpackage

// ===== sv/bfkn_if.sv =====
// Interfaces: input item, result item and configuration write channels.
interface bfkn_in_if;
	import bfkn_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [IDX_W-1:0]          point_index;
	logic signed [15:0]        coord_0;
	logic signed [15:0]        coord_1;
	logic signed [15:0]        coord_2;
	logic signed [15:0]        coord_3;
	modport source (output valid, mode, point_index, coord_0, coord_1, coord_2, coord_3,
		input ready);
	modport sink (input valid, mode, point_index, coord_0, coord_1, coord_2, coord_3,
		output ready);
endinterface

interface bfkn_out_if;
	import bfkn_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  neighbor_index;
	logic [RANK_W-1:0] neighbor_rank;
	logic [DIST_W-1:0] squared_distance;
	logic              last;
	modport source (output valid, neighbor_index, neighbor_rank, squared_distance, last,
		input ready);
	modport sink (input valid, neighbor_index, neighbor_rank, squared_distance, last,
		output ready);
endinterface

interface bfkn_cfg_if;
	import bfkn_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/bfkn_dist_lane.sv =====
// Distance lane: squared difference of one coordinate, two pipeline stages.
module bfkn_dist_lane #(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic signed [COORD_BITS-1:0] stored,
	input  logic signed [COORD_BITS-1:0] query,
	output logic [2*COORD_BITS-1:0]      sq
);
	logic [COORD_BITS:0] mag_s1;
	logic signed [COORD_BITS:0] diff;

	// Take magnitude of the difference
	always_comb begin
		diff = {stored[COORD_BITS-1], stored} - {query[COORD_BITS-1], query};
	end

	always_ff @(posedge clk) begin
		mag_s1 <= diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : diff;
	end

	// Square the magnitude
	always_ff @(posedge clk) begin
		sq <= (2*COORD_BITS)'(mag_s1 * mag_s1);
	end
endmodule

// ===== sv/bfkn_best_list.sv =====
// Sorted candidate list: insertion of one offered distance per cycle.
module bfkn_best_list #(
	parameter int MAX_NEIGHBORS = 16,
	parameter int IW = 10,
	parameter int DW = 34
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfkn_pkg::list_ctrl_t          ctrl,
	input  logic [$clog2(MAX_NEIGHBORS+1)-1:0] k,
	input  logic [DW-1:0]                 cand_dist,
	input  logic [IW-1:0]                 idx,
	input  logic [$clog2(MAX_NEIGHBORS)-1:0] rd_sel,
	output logic [DW-1:0]                 rd_dist,
	output logic [IW-1:0]                 rd_idx,
	output logic [$clog2(MAX_NEIGHBORS+1)-1:0] fill
);
	import bfkn_pkg::*;
	localparam int FW = $clog2(MAX_NEIGHBORS+1);

	logic [DW-1:0] dist_q [MAX_NEIGHBORS];
	logic [IW-1:0] idx_q  [MAX_NEIGHBORS];
	logic [FW-1:0] fill_q;
	logic [MAX_NEIGHBORS-1:0] occ, gt;

	// Per slot: valid and strictly farther than the new distance
	always_comb begin
		for (int j = 0; j < MAX_NEIGHBORS; j++) begin
			occ[j] = FW'(j) < fill_q;
			gt[j]  = occ[j] && (dist_q[j] > cand_dist);
		end
	end

	// Shift farther entries down one place, insert at the first of them, or append when none is farther and there is room
	always_ff @(posedge clk) begin
		if (ctrl.offer) begin
			for (int j = 0; j < MAX_NEIGHBORS; j++) begin
				if (FW'(j) < k) begin
					if (j > 0 && gt[j-1]) begin
						dist_q[j] <= dist_q[j-1];
						idx_q[j]  <= idx_q[j-1];
					end else if (gt[j] || (!occ[j] && (j == 0 || occ[j-1]))) begin
						dist_q[j] <= cand_dist;
						idx_q[j]  <= idx;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.clear) begin
			fill_q <= '0;
		end else if (ctrl.offer && fill_q < k) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	assign rd_dist = dist_q[rd_sel];
	assign rd_idx  = idx_q[rd_sel];
	assign fill    = fill_q;

	fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_NEIGHBORS))
		else $error("candidate fill beyond list depth");
	fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.clear && !ctrl.offer |=> fill_q == $past(fill_q))
		else $error("fill changed without offer");
	clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> fill_q == '0)
		else $error("clear did not empty list");
endmodule

// ===== sv/brute_force_k_nearest.sv =====
// Top level: point table, distance lanes, candidate list and result sequencer.
// A store item is written into the point table when accepted. A query scans
// stored points 0 to point_count-1 at one point per cycle through a table
// memory read port, four coordinate lanes and an adder stage, inserts each
// distance into a sorted list of neighbor_count candidates, then presents
// one result per cycle while the sink takes them.
// Table contents are undefined until written.
module brute_force_k_nearest #(
	parameter int MAX_POINTS    = bfkn_pkg::MAX_POINTS_DEF,
	parameter int MAX_NEIGHBORS = bfkn_pkg::MAX_NEIGHBORS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	bfkn_in_if.sink   in_ch,
	bfkn_out_if.source out_ch,
	bfkn_cfg_if.sink  cfg
);
	import bfkn_pkg::*;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS+1);
	localparam int FW = $clog2(MAX_NEIGHBORS+1);
	localparam int SW = $clog2(MAX_NEIGHBORS);
	localparam int CB = COORD_BITS_DEF;
	localparam int LAT = 4;
	localparam int IW_T = IDX_W;

	state_t state_q, state_d;
	logic [NCNT_W-1:0] ncount_q;
	logic [PCNT_W-1:0] pcount_q;
	logic [4*CB-1:0] table_mem [MAX_POINTS];
	logic [4*CB-1:0] rd_s1;
	logic [4*CB-1:0] query_q;
	logic [CNT_W-1:0] scan_q, nlim;
	logic [LAT-1:0] vpipe_q;
	logic [IW_T-1:0] ipipe_q [LAT];
	logic [2*CB-1:0] sq [4];
	logic [DIST_W-1:0] sum_s3;
	logic [FW-1:0] k, fill;
	logic [SW-1:0] rank_q;
	logic [DIST_W-1:0] rd_dist;
	logic [IDX_W-1:0] rd_idx;
	list_ctrl_t lctrl;
	logic in_fire, out_fire, scan_go;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign cfg.ready = 1'b1;
	assign in_ch.ready = state_q == ST_IDLE;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q <= NCNT_W'(1);
			pcount_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NEIGHBOR_COUNT: ncount_q <= cfg.data[NCNT_W-1:0];
				REG_POINT_COUNT:    pcount_q <= cfg.data[PCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp counts
	always_comb begin
		if (ncount_q == '0) k = FW'(1);
		else if (32'(ncount_q) > MAX_NEIGHBORS) k = FW'(MAX_NEIGHBORS);
		else k = FW'(ncount_q);
		if (32'(pcount_q) > MAX_POINTS) nlim = CNT_W'(MAX_POINTS);
		else nlim = CNT_W'(pcount_q);
	end

	// Point table: write on store, read one point per scan cycle
	assign scan_go = state_q == ST_SCAN && scan_q < nlim;
	always_ff @(posedge clk) begin
		if (in_fire && in_ch.mode == MODE_STORE && 32'(in_ch.point_index) < MAX_POINTS)
			table_mem[AW'(in_ch.point_index)] <=
				{in_ch.coord_3, in_ch.coord_2, in_ch.coord_1, in_ch.coord_0};
		rd_s1 <= table_mem[scan_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (in_fire) query_q <= {in_ch.coord_3, in_ch.coord_2, in_ch.coord_1, in_ch.coord_0};
	end

	// Coordinate lanes
	for (genvar d = 0; d < 4; d++) begin : g_lane
		bfkn_dist_lane #(.COORD_BITS(CB)) u_lane (
			.clk(clk),
			.stored(rd_s1[d*CB +: CB]),
			.query(query_q[d*CB +: CB]),
			.sq(sq[d])
		);
	end

	// Merge the lanes
	always_ff @(posedge clk) begin
		sum_s3 <= DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]) + DIST_W'(sq[3]);
	end

	// Track valid and index alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpipe_q <= '0;
		end else begin
			vpipe_q <= {vpipe_q[LAT-2:0], scan_go};
		end
	end
	always_ff @(posedge clk) begin
		ipipe_q[0] <= IDX_W'(scan_q);
		for (int s = 1; s < LAT; s++) ipipe_q[s] <= ipipe_q[s-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			rank_q <= '0;
		end else begin
			if (in_fire) scan_q <= '0;
			else if (scan_go) scan_q <= scan_q + 1'b1;
			if (state_q != ST_EMIT) rank_q <= '0;
			else if (out_fire) rank_q <= rank_q + 1'b1;
		end
	end

	assign lctrl.clear = in_fire && in_ch.mode == MODE_QUERY;
	assign lctrl.offer = vpipe_q[LAT-1];

	bfkn_best_list #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .IW(IDX_W), .DW(DIST_W)) u_list (
		.clk(clk), .arst_n(arst_n), .ctrl(lctrl), .k(k),
		.cand_dist(sum_s3), .idx(ipipe_q[LAT-1]),
		.rd_sel(rank_q), .rd_dist(rd_dist), .rd_idx(rd_idx), .fill(fill)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_fire && in_ch.mode == MODE_QUERY) state_d = ST_SCAN;
			ST_SCAN:  if (!scan_go) state_d = ST_DRAIN;
			ST_DRAIN: if (vpipe_q == '0) state_d = (fill == '0) ? ST_IDLE : ST_EMIT;
			ST_EMIT:  if (out_fire && FW'(rank_q) + 1'b1 == fill) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Outputs
	always_comb begin
		out_ch.valid = state_q == ST_EMIT;
		out_ch.neighbor_index = rd_idx;
		out_ch.neighbor_rank = RANK_W'(rank_q);
		out_ch.squared_distance = rd_dist;
		out_ch.last = FW'(rank_q) + 1'b1 == fill;
	end

	no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready)
		else $error("input taken while busy");
	emit_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> FW'(rank_q) < fill)
		else $error("rank beyond candidate fill");
	no_offer_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> vpipe_q == '0)
		else $error("distance pipeline busy during output");
endmodule
